// ===== src/cln_pkg.sv =====
package cln_pkg;

    localparam int CFG_WIDTH = 16;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_POWERUP = 6'b000010,
        PH_EN_HIGH = 6'b000100,
        PH_EN_LOW  = 6'b001000,
        PH_POST    = 6'b010000,
        PH_GAP     = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_DATA    = 3'd1,
        MODE_TEXT    = 3'd2,
        MODE_COMMAND = 3'd3,
        MODE_CURSOR  = 3'd4,
        MODE_INIT    = 3'd5
    } mode_t;

    localparam logic [2:0] CFG_ENABLE_PULSE = 3'd0;
    localparam logic [2:0] CFG_COMMAND_WAIT = 3'd1;
    localparam logic [2:0] CFG_DATA_WAIT    = 3'd2;
    localparam logic [2:0] CFG_INIT_GAP     = 3'd3;
    localparam logic [2:0] CFG_POWERUP_WAIT = 3'd4;

    localparam logic [CFG_WIDTH-1:0] RST_ENABLE_PULSE = 16'd50;
    localparam logic [CFG_WIDTH-1:0] RST_COMMAND_WAIT = 16'd2000;
    localparam logic [CFG_WIDTH-1:0] RST_DATA_WAIT    = 16'd50;
    localparam logic [CFG_WIDTH-1:0] RST_INIT_GAP     = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] RST_POWERUP_WAIT = 16'd20000;

    localparam logic [2:0] INIT_COUNT   = 3'd5;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CMD_LINE_TWO = 8'hC0;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW_OFFSET   = 8'h40;
    localparam logic [7:0] MAX_COLUMN   = 8'd15;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] enable_pulse_us;
        logic [CFG_WIDTH-1:0] command_wait_us;
        logic [CFG_WIDTH-1:0] data_wait_us;
        logic [CFG_WIDTH-1:0] init_gap_us;
        logic [CFG_WIDTH-1:0] powerup_wait_us;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] pending_byte;
        logic       second_nibble;
        logic       select_level;
        logic [2:0] init_step;
        logic       in_init;
    } ctl_t;

    typedef struct packed {
        logic       register_select;
        logic [3:0] bus_nibble;
        logic       enable_line;
        logic       ready_res;
        logic       rejected;
    } result_t;

    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h01;
            default: b = 8'h33;
        endcase
        return b;
    endfunction

endpackage

// ===== src/cln_step.sv =====
module cln_step #(
    parameter int TIMER_BITS = 16
) (
    input  cln_pkg::ctl_t          cur,
    input  logic [TIMER_BITS-1:0]  cnt,
    input  cln_pkg::cfg_t          cfg,
    input  logic [2:0]             mode,
    input  logic [7:0]             byte_value,
    input  logic [7:0]             column,
    input  logic [7:0]             row,
    output cln_pkg::ctl_t          nxt,
    output logic [TIMER_BITS-1:0]  cnt_next,
    output cln_pkg::result_t       res
);
    import cln_pkg::*;

    localparam logic [63:0] TMAX = (64'd1 << TIMER_BITS) - 64'd1;

    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_WIDTH-1:0] v);
        logic [63:0] v64;
        v64 = 64'(v);
        return (v64 > TMAX) ? TMAX[TIMER_BITS-1:0] : v64[TIMER_BITS-1:0];
    endfunction

    logic [TIMER_BITS-1:0] pulse_load;
    logic [TIMER_BITS-1:0] post_load;
    logic [TIMER_BITS-1:0] gap_load;
    logic [TIMER_BITS-1:0] powerup_load;
    logic [TIMER_BITS-1:0] cnt_dec;
    logic [3:0]            col_clamped;
    logic [7:0]            cursor_byte;
    logic                  busy;
    logic                  run_adv;
    logic                  post_done;
    logic                  gap_done;
    logic                  rej;
    logic [2:0]            step_inc;

    assign busy         = (cur.phase != PH_IDLE);
    assign pulse_load   = timer_load((cfg.enable_pulse_us == '0) ? CFG_WIDTH'(1)
                                                                 : cfg.enable_pulse_us);
    assign post_load    = timer_load(cur.select_level ? cfg.data_wait_us
                                                      : cfg.command_wait_us);
    assign gap_load     = timer_load(cfg.init_gap_us);
    assign powerup_load = timer_load(cfg.powerup_wait_us);
    assign cnt_dec      = (cnt != '0) ? cnt - TIMER_BITS'(1) : cnt;
    assign col_clamped  = (column > MAX_COLUMN) ? MAX_COLUMN[3:0] : column[3:0];
    assign cursor_byte  = CMD_SET_ADDR + ((row != 8'd0) ? ROW_OFFSET : 8'd0)
                        + {4'd0, col_clamped};
    assign step_inc     = cur.init_step + 3'd1;

    always_comb
    begin
        nxt       = cur;
        cnt_next  = cnt;
        rej       = 1'b0;
        run_adv   = 1'b0;
        post_done = 1'b0;
        gap_done  = 1'b0;

        case (mode)
            MODE_TICK:
            begin
                if (busy)
                begin
                    cnt_next = cnt_dec;
                    run_adv  = (cnt_dec == '0);
                end
            end
            MODE_DATA, MODE_TEXT, MODE_COMMAND, MODE_CURSOR:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    nxt.second_nibble = 1'b0;
                    nxt.phase         = PH_EN_HIGH;
                    cnt_next          = pulse_load;
                    if (mode == MODE_DATA)
                    begin
                        nxt.pending_byte = byte_value;
                        nxt.select_level = 1'b1;
                    end
                    else if (mode == MODE_TEXT)
                    begin
                        // newline moves the cursor to the second line
                        nxt.pending_byte = (byte_value == CHAR_NEWLINE) ? CMD_LINE_TWO
                                                                        : byte_value;
                        nxt.select_level = (byte_value != CHAR_NEWLINE);
                    end
                    else if (mode == MODE_COMMAND)
                    begin
                        nxt.pending_byte = byte_value;
                        nxt.select_level = 1'b0;
                    end
                    else
                    begin
                        nxt.pending_byte = cursor_byte;
                        nxt.select_level = 1'b0;
                    end
                end
            end
            MODE_INIT:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    nxt.in_init   = 1'b1;
                    nxt.init_step = 3'd0;
                    nxt.phase     = PH_POWERUP;
                    cnt_next      = powerup_load;
                    run_adv       = (powerup_load == '0);
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        // phase ran out: move on, skipping phases whose wait is zero
        if (run_adv)
        begin
            case (nxt.phase)
                PH_POWERUP:
                begin
                    nxt.pending_byte  = init_byte((nxt.init_step < INIT_COUNT) ?
                                                  nxt.init_step : 3'd0);
                    nxt.select_level  = 1'b0;
                    nxt.second_nibble = 1'b0;
                    nxt.phase         = PH_EN_HIGH;
                    cnt_next          = pulse_load;
                end
                PH_EN_HIGH:
                begin
                    nxt.phase = PH_EN_LOW;
                    cnt_next  = pulse_load;
                end
                PH_EN_LOW:
                begin
                    if (!nxt.second_nibble)
                    begin
                        nxt.second_nibble = 1'b1;
                        nxt.phase         = PH_EN_HIGH;
                        cnt_next          = pulse_load;
                    end
                    else if (post_load != '0)
                    begin
                        nxt.phase = PH_POST;
                        cnt_next  = post_load;
                    end
                    else
                    begin
                        post_done = 1'b1;
                    end
                end
                PH_POST:
                begin
                    post_done = 1'b1;
                end
                PH_GAP:
                begin
                    gap_done = 1'b1;
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end

        if (post_done)
        begin
            cnt_next = '0;
            if (!nxt.in_init)
            begin
                nxt.phase = PH_IDLE;
            end
            else if (gap_load != '0)
            begin
                nxt.phase = PH_GAP;
                cnt_next  = gap_load;
            end
            else
            begin
                gap_done = 1'b1;
            end
        end

        if (gap_done)
        begin
            nxt.init_step = step_inc;
            if (step_inc >= INIT_COUNT)
            begin
                nxt.in_init = 1'b0;
                nxt.phase   = PH_IDLE;
            end
            else
            begin
                nxt.pending_byte  = init_byte(step_inc);
                nxt.select_level  = 1'b0;
                nxt.second_nibble = 1'b0;
                nxt.phase         = PH_EN_HIGH;
                cnt_next          = pulse_load;
            end
        end
    end

    always_comb
    begin
        res.register_select = nxt.select_level;
        res.bus_nibble      = nxt.second_nibble ? nxt.pending_byte[3:0]
                                                : nxt.pending_byte[7:4];
        res.enable_line     = (nxt.phase == PH_EN_HIGH);
        res.ready_res       = (nxt.phase == PH_IDLE);
        res.rejected        = rej;
    end

endmodule

// ===== src/cln_outreg.sv =====
module cln_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cln_pkg::result_t  d,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              in_ready,
    output cln_pkg::result_t  q
);
    import cln_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // take a new request whenever no result is held or the held result leaves this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (load)
        begin
            data_reg <= d;
        end
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

// ===== src/char_lcd_nibble_sequencer.sv =====
// Character display sequencer for a two-line display on a 4-bit bus.
// Input channel (in_valid/in_ready): one item per request; mode 0 is a
// one-microsecond tick, modes 1..5 send a data byte, a text character,
// a raw command, a cursor position or the init sequence.
// Output channel (out_valid/out_ready): exactly one result per input item,
// carrying the pin levels after that item, ready_res and rejected.
// The result of an item accepted at edge n is registered and valid after
// edge n. Throughput is one item per cycle while results are taken; all
// work for an item is a single pass of the state update between the state
// registers and the result register. Waits are counted in tick items, not
// in clocks. When the receiver stalls, the result register holds and
// in_ready drops until it is taken; a result leaving in the same cycle
// frees the slot. Reset clears the sequencer to idle with all pins low and
// loads the timing registers with defaults. The cfg port writes a timing
// register; users must use it only with no item in flight (unchecked).
module char_lcd_nibble_sequencer #(
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_value,
    input  logic [7:0]  column,
    input  logic [7:0]  row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        register_select,
    output logic [3:0]  bus_nibble,
    output logic        enable_line,
    output logic        ready_res,
    output logic        rejected,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [cln_pkg::CFG_WIDTH-1:0] cfg_data
);
    import cln_pkg::*;

    cfg_t                  cfg_reg;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [TIMER_BITS-1:0] cnt_reg;
    logic [TIMER_BITS-1:0] cnt_next;
    result_t               res_d;
    result_t               res_q;
    logic                  accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_pulse_us <= RST_ENABLE_PULSE;
            cfg_reg.command_wait_us <= RST_COMMAND_WAIT;
            cfg_reg.data_wait_us    <= RST_DATA_WAIT;
            cfg_reg.init_gap_us     <= RST_INIT_GAP;
            cfg_reg.powerup_wait_us <= RST_POWERUP_WAIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENABLE_PULSE: cfg_reg.enable_pulse_us <= cfg_data;
                CFG_COMMAND_WAIT: cfg_reg.command_wait_us <= cfg_data;
                CFG_DATA_WAIT:    cfg_reg.data_wait_us    <= cfg_data;
                CFG_INIT_GAP:     cfg_reg.init_gap_us     <= cfg_data;
                CFG_POWERUP_WAIT: cfg_reg.powerup_wait_us <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase         <= PH_IDLE;
            ctl_reg.pending_byte  <= 8'd0;
            ctl_reg.second_nibble <= 1'b0;
            ctl_reg.select_level  <= 1'b0;
            ctl_reg.init_step     <= 3'd0;
            ctl_reg.in_init       <= 1'b0;
            cnt_reg               <= '0;
        end
        else if (accept)
        begin
            ctl_reg <= ctl_next;
            cnt_reg <= cnt_next;
        end
    end

    cln_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cur        (ctl_reg),
        .cnt        (cnt_reg),
        .cfg        (cfg_reg),
        .mode       (mode),
        .byte_value (byte_value),
        .column     (column),
        .row        (row),
        .nxt        (ctl_next),
        .cnt_next   (cnt_next),
        .res        (res_d)
    );

    cln_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .d         (res_d),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .in_ready  (in_ready),
        .q         (res_q)
    );

    assign register_select = res_q.register_select;
    assign bus_nibble      = res_q.bus_nibble;
    assign enable_line     = res_q.enable_line;
    assign ready_res       = res_q.ready_res;
    assign rejected        = res_q.rejected;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    a_reject_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> !ready_res)
        else $error("rejected result reports ready");

    a_idle_not_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.phase == PH_IDLE) |-> !ctl_reg.in_init)
        else $error("idle while init sequence still active");

    a_init_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.in_init |-> (ctl_reg.init_step < INIT_COUNT))
        else $error("init step out of range");

    a_enable_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && enable_line) |-> !ready_res)
        else $error("enable strobe high while ready");

endmodule
